// ===== src/t8ce_pkg.sv =====
`default_nettype none

package t8ce_pkg;

  // instruction codes
  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_LOAD   = 4'd1,
    OP_STORE  = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_HALVE  = 4'd5,
    OP_DOUBLE = 4'd6,
    OP_JMP    = 4'd7,
    OP_JIN    = 4'd8,
    OP_JIZ    = 4'd9,
    OP_JIA    = 4'd10,
    OP_OUT    = 4'd11,
    OP_HALT   = 4'd12,
    OP_LUI    = 4'd13,
    OP_LLI    = 4'd14,
    OP_INC    = 4'd15
  } op_t;

  // one decoded instruction
  typedef struct packed {
    op_t        opcode;
    logic [3:0] immediate;
    logic [1:0] mem_index;
    logic       dest_reg;
    logic       src_reg;
    logic       out_from_registers;
  } instr_t;

  typedef struct packed {
    logic overflow;
    logic negative;
    logic zero;
    logic above;
  } flags_t;

  // visible machine state after one step
  typedef struct packed {
    logic [3:0] next_index;
    logic [7:0] out_value;
    logic [7:0] reg_zero;
    logic [7:0] reg_one;
    flags_t     flags;
    logic       halted;
  } result_t;

  localparam logic [7:0] BYTE_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== src/tiny_8bit_cpu_execute_top.sv =====
// Execute stage of a tiny 8-bit machine: one decoded instruction per input beat.
// Input channel: in_valid / in_ready with opcode, immediate, mem_index,
// dest_reg, src_reg and out_from_registers. Output channel: out_valid /
// out_ready with the machine state after that instruction (index, output byte,
// both registers, four flags, halted mark); exactly one result beat per input.
// An accepted beat waits in the instruction register and executes against the
// machine state once the result register can take it; the result register and
// the machine state load together, and the result is shown from then on.
// Throughput: one instruction per cycle while out_ready is high; execution is
// one pass of byte-wide add, subtract and shift logic from the instruction
// register to the result register, and the machine state updates at the same edge.
// Reset (rst, synchronous): registers, data memory, index, flags, output byte
// and halted mark clear, both stages empty.
// Stall: while out_ready is low the result holds; one more instruction can wait
// in the instruction register, then in_ready drops until the result leaves.
// Once halted, further instructions are taken and report the unchanged state.
`default_nettype none

module tiny_8bit_cpu_execute_top #(
  parameter int PROGRAM_SLOTS = 16,
  parameter int MEMORY_SLOTS  = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] opcode,
  input  wire logic [3:0] immediate,
  input  wire logic [1:0] mem_index,
  input  wire logic       dest_reg,
  input  wire logic       src_reg,
  input  wire logic       out_from_registers,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      next_index,
  output logic [7:0]      out_value,
  output logic [7:0]      reg_zero,
  output logic [7:0]      reg_one,
  output logic            overflow_flag,
  output logic            negative_flag,
  output logic            zero_flag,
  output logic            above_flag,
  output logic            halted
);
  import t8ce_pkg::*;

  instr_t  in_instr;
  instr_t  instr;
  result_t result;
  result_t out_result;
  logic    fire;
  logic    take;

  // pack the incoming beat
  always_comb begin
    in_instr.opcode             = op_t'(opcode);
    in_instr.immediate          = immediate;
    in_instr.mem_index          = mem_index;
    in_instr.dest_reg           = dest_reg;
    in_instr.src_reg            = src_reg;
    in_instr.out_from_registers = out_from_registers;
  end

  t8ce_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_instr (in_instr),
    .take     (take),
    .fire     (fire),
    .instr    (instr)
  );

  t8ce_core #(
    .PROGRAM_SLOTS (PROGRAM_SLOTS),
    .MEMORY_SLOTS  (MEMORY_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .instr  (instr),
    .result (result)
  );

  t8ce_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .result     (result),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  // unpack the result beat
  assign next_index    = out_result.next_index;
  assign out_value     = out_result.out_value;
  assign reg_zero      = out_result.reg_zero;
  assign reg_one       = out_result.reg_one;
  assign overflow_flag = out_result.flags.overflow;
  assign negative_flag = out_result.flags.negative;
  assign zero_flag     = out_result.flags.zero;
  assign above_flag    = out_result.flags.above;
  assign halted        = out_result.halted;

endmodule

`default_nettype wire

// ===== src/t8ce_in_stage.sv =====
`default_nettype none

module t8ce_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire t8ce_pkg::instr_t in_instr,
  input  wire logic             take,
  output logic                  fire,
  output t8ce_pkg::instr_t      instr
);
  import t8ce_pkg::*;

  logic held;

  // execute when an instruction is held and the result register can take it
  assign fire     = held && take;
  assign in_ready = !held || take;

  // holding flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  // instruction register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      instr <= in_instr;
    end
  end

endmodule

`default_nettype wire

// ===== src/t8ce_core.sv =====
`default_nettype none

module t8ce_core #(
  parameter int PROGRAM_SLOTS = 16,
  parameter int MEMORY_SLOTS  = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire t8ce_pkg::instr_t instr,
  output t8ce_pkg::result_t     result
);
  import t8ce_pkg::*;

  localparam int IW = $clog2(PROGRAM_SLOTS);
  localparam int MW = (MEMORY_SLOTS > 1) ? $clog2(MEMORY_SLOTS) : 1;

  // architectural state
  logic [7:0]    regs [2];
  logic [7:0]    mem  [MEMORY_SLOTS];
  logic [IW-1:0] idx;
  flags_t        flags;
  logic [7:0]    out_byte;
  logic          halt;

  logic [7:0]    regs_next [2];
  logic [IW-1:0] idx_next;
  flags_t        flags_next;
  logic [7:0]    out_byte_next;
  logic          halt_next;
  logic          mem_wr;

  logic [4:0]    slot_w;
  logic [MW-1:0] slot;
  logic [8:0]    tgt_w;
  logic [IW-1:0] target;
  logic [IW-1:0] idx_inc;
  logic [7:0]    src_val;
  logic [7:0]    mem_val;
  logic [9:0]    res;
  logic [IW+3:0] idx_ext;

  // memory slot and jump target reduced into range
  always_comb begin
    slot_w = {3'b000, instr.mem_index};
    for (int k = 0; k < 3; k++) begin
      if (slot_w >= 5'(MEMORY_SLOTS)) begin
        slot_w = slot_w - 5'(MEMORY_SLOTS);
      end
    end
    slot = MW'(slot_w);
    tgt_w = {5'b00000, instr.immediate};
    for (int k = 0; k < 7; k++) begin
      if (tgt_w >= 9'(PROGRAM_SLOTS)) begin
        tgt_w = tgt_w - 9'(PROGRAM_SLOTS);
      end
    end
    target = IW'(tgt_w);
  end

  assign idx_inc = (idx == IW'(PROGRAM_SLOTS - 1)) ? '0 : idx + IW'(1);
  assign src_val = regs[instr.src_reg];
  assign mem_val = mem[slot];

  // unwrapped arithmetic result, two's complement over ten bits
  always_comb begin
    case (instr.opcode)
      OP_ADD:    res = {2'b00, regs[0]} + {2'b00, regs[1]};
      OP_SUB:    res = {2'b00, regs[!instr.src_reg]} - {2'b00, src_val};
      OP_HALVE:  res = {3'b000, src_val[7:1]};
      OP_DOUBLE: res = {1'b0, src_val, 1'b0};
      default:   res = {2'b00, src_val} + 10'd1;
    endcase
  end

  // next state
  always_comb begin
    regs_next[0]  = regs[0];
    regs_next[1]  = regs[1];
    idx_next      = idx_inc;
    flags_next    = flags;
    out_byte_next = out_byte;
    halt_next     = halt;
    mem_wr        = 1'b0;
    if (halt) begin
      idx_next = idx;
    end else begin
      unique case (instr.opcode)
        OP_NOP: begin
        end
        OP_LOAD: begin
          regs_next[instr.dest_reg] = mem_val;
        end
        OP_STORE: begin
          mem_wr = 1'b1;
        end
        OP_ADD, OP_SUB, OP_HALVE, OP_DOUBLE, OP_INC: begin
          flags_next.overflow       = !res[9] && res[8];
          flags_next.negative       = res[9];
          flags_next.zero           = (res == 10'd0);
          flags_next.above          = !res[9] && (res != 10'd0);
          regs_next[instr.dest_reg] = res[7:0] & BYTE_MAX;
        end
        OP_JMP: begin
          idx_next = target;
        end
        OP_JIN: begin
          if (flags.negative) idx_next = target;
        end
        OP_JIZ: begin
          if (flags.zero) idx_next = target;
        end
        OP_JIA: begin
          if (flags.above) idx_next = target;
        end
        OP_OUT: begin
          out_byte_next = instr.out_from_registers ? regs[instr.dest_reg] : mem_val;
        end
        OP_HALT: begin
          halt_next = 1'b1;
          idx_next  = idx;
        end
        OP_LUI: begin
          regs_next[0] = {instr.immediate, 4'h0};
        end
        OP_LLI: begin
          regs_next[0] = regs[0] | {4'h0, instr.immediate};
        end
      endcase
    end
  end

  // state registers, updated as each instruction executes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0]  <= '0;
      regs[1]  <= '0;
      idx      <= '0;
      flags    <= '0;
      out_byte <= '0;
      halt     <= 1'b0;
      for (int i = 0; i < MEMORY_SLOTS; i++) begin
        mem[i] <= '0;
      end
    end else if (fire) begin
      regs[0]  <= regs_next[0];
      regs[1]  <= regs_next[1];
      idx      <= idx_next;
      flags    <= flags_next;
      out_byte <= out_byte_next;
      halt     <= halt_next;
      if (mem_wr) begin
        mem[slot] <= regs[instr.dest_reg];
      end
    end
  end

  // reported state
  always_comb begin
    idx_ext           = (IW + 4)'(idx_next);
    result.next_index = idx_ext[3:0];
    result.out_value  = out_byte_next;
    result.reg_zero   = regs_next[0];
    result.reg_one    = regs_next[1];
    result.flags      = flags_next;
    result.halted     = halt_next;
  end

endmodule

`default_nettype wire

// ===== src/t8ce_out_stage.sv =====
`default_nettype none

module t8ce_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire t8ce_pkg::result_t result,
  output logic                   take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output t8ce_pkg::result_t      out_result
);
  import t8ce_pkg::*;

  // room for a new beat when empty or when the current one leaves
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

endmodule

`default_nettype wire

// ===== src/t8ce_checker.sv =====
`default_nettype none

module t8ce_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] next_index,
  input wire logic [7:0] out_value,
  input wire logic [7:0] reg_zero,
  input wire logic [7:0] reg_one,
  input wire logic       overflow_flag,
  input wire logic       negative_flag,
  input wire logic       zero_flag,
  input wire logic       above_flag,
  input wire logic       halted
);

  // a stalled result beat holds its state
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(next_index)
      && $stable(reg_zero) && $stable(reg_one) && $stable(out_value)))
    else $error("result beat changed while stalled");

  // sign flags are exclusive, overflow only on a positive result
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($onehot0({negative_flag, zero_flag, above_flag})
      && (!overflow_flag || above_flag)))
    else $error("inconsistent flags");

  // halted is sticky and freezes the machine
  a_halt_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && halted) |=> (!out_valid || (halted
      && next_index == $past(next_index) && reg_zero == $past(reg_zero)
      && reg_one == $past(reg_one) && out_value == $past(out_value))))
    else $error("state changed after halt");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tiny_8bit_cpu_execute_top t8ce_checker u_t8ce_checker (.*);

`default_nettype wire

// ===== bench/tiny_8bit_cpu_execute_top_test.sv =====
`default_nettype none

module tiny_8bit_cpu_execute_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import t8ce_pkg::*;

  localparam int PROG_SLOTS = 16;
  localparam int MEM_SLOTS  = 4;
  localparam int HOLD_CYCLES = 40;

  // expected machine state, one entry per accepted instruction beat
  class exec_scoreboard;
    logic [7:0] regs [2];
    logic [7:0] dmem [MEM_SLOTS];
    logic [3:0] pc;
    flags_t     fl;
    logic [7:0] out_byte;
    logic       stopped;
    result_t    state_q [$];
    int         errors;

    function new();
      regs[0] = '0;
      regs[1] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      fl = '0;
      out_byte = '0;
      stopped = 1'b0;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // execute one instruction against the shadow machine
    function void note_instr(instr_t ins);
      int      val;
      int      nxt;
      int      slot;
      int      target;
      result_t r;
      slot = ins.mem_index % MEM_SLOTS;
      target = ins.immediate % PROG_SLOTS;
      if (!stopped) begin
        nxt = (pc + 1) % PROG_SLOTS;
        case (ins.opcode)
          OP_NOP: ;
          OP_LOAD: regs[ins.dest_reg] = dmem[slot];
          OP_STORE: dmem[slot] = regs[ins.dest_reg];
          OP_ADD, OP_SUB, OP_HALVE, OP_DOUBLE, OP_INC: begin
            case (ins.opcode)
              OP_ADD:    val = int'(regs[0]) + int'(regs[1]);
              OP_SUB:    val = int'(regs[!ins.src_reg]) - int'(regs[ins.src_reg]);
              OP_HALVE:  val = int'(regs[ins.src_reg]) / 2;
              OP_DOUBLE: val = int'(regs[ins.src_reg]) * 2;
              default:   val = int'(regs[ins.src_reg]) + 1;
            endcase
            fl.overflow = (val > 255);
            fl.negative = (val < 0);
            fl.zero     = (val == 0);
            fl.above    = (val > 0);
            regs[ins.dest_reg] = val[7:0];
          end
          OP_JMP: nxt = target;
          OP_JIN: if (fl.negative) nxt = target;
          OP_JIZ: if (fl.zero) nxt = target;
          OP_JIA: if (fl.above) nxt = target;
          OP_OUT: out_byte = ins.out_from_registers ? regs[ins.dest_reg] : dmem[slot];
          OP_HALT: begin
            stopped = 1'b1;
            nxt = pc;
          end
          OP_LUI: regs[0] = {ins.immediate, 4'h0};
          OP_LLI: regs[0] = regs[0] | {4'h0, ins.immediate};
          default: ;
        endcase
        pc = nxt[3:0];
      end
      r.next_index = pc;
      r.out_value  = out_byte;
      r.reg_zero   = regs[0];
      r.reg_one    = regs[1];
      r.flags      = fl;
      r.halted     = stopped;
      state_q.insert(state_q.size(), r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (state_q.size() == 0) begin
        report($sformatf("result beat with nothing pending: idx=%h out=%h r0=%h r1=%h",
                         got.next_index, got.out_value, got.reg_zero, got.reg_one));
        return;
      end
      want = state_q.pop_front();
      if (got.next_index !== want.next_index || got.out_value !== want.out_value ||
          got.reg_zero !== want.reg_zero || got.reg_one !== want.reg_one ||
          got.flags !== want.flags || got.halted !== want.halted) begin
        report($sformatf({"result mismatch: exp idx=%h out=%h r0=%h r1=%h f=%b h=%b",
                          " / got idx=%h out=%h r0=%h r1=%h f=%b h=%b"},
                         want.next_index, want.out_value, want.reg_zero, want.reg_one,
                         want.flags, want.halted,
                         got.next_index, got.out_value, got.reg_zero, got.reg_one,
                         got.flags, got.halted));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] opcode;
  logic [3:0] immediate;
  logic [1:0] mem_index;
  logic       dest_reg;
  logic       src_reg;
  logic       out_from_registers;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] next_index;
  logic [7:0] out_value;
  logic [7:0] reg_zero;
  logic [7:0] reg_one;
  logic       overflow_flag;
  logic       negative_flag;
  logic       zero_flag;
  logic       above_flag;
  logic       halted;

  bit idle_on;
  bit hold_req;

  exec_scoreboard sb;

  tiny_8bit_cpu_execute_top dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .opcode             (opcode),
    .immediate          (immediate),
    .mem_index          (mem_index),
    .dest_reg           (dest_reg),
    .src_reg            (src_reg),
    .out_from_registers (out_from_registers),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .next_index         (next_index),
    .out_value          (out_value),
    .reg_zero           (reg_zero),
    .reg_one            (reg_one),
    .overflow_flag      (overflow_flag),
    .negative_flag      (negative_flag),
    .zero_flag          (zero_flag),
    .above_flag         (above_flag),
    .halted             (halted)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watch both channels at each edge
  always @(posedge clk) begin : watch
    instr_t  seen;
    result_t got;
    if (!rst && in_valid && in_ready) begin
      seen.opcode = op_t'(opcode);
      seen.immediate = immediate;
      seen.mem_index = mem_index;
      seen.dest_reg = dest_reg;
      seen.src_reg = src_reg;
      seen.out_from_registers = out_from_registers;
      sb.note_instr(seen);
    end
    if (!rst && out_valid && out_ready) begin
      got.next_index = next_index;
      got.out_value = out_value;
      got.reg_zero = reg_zero;
      got.reg_one = reg_one;
      got.flags = '{overflow_flag, negative_flag, zero_flag, above_flag};
      got.halted = halted;
      sb.check_result(got);
    end
  end

  // result side: ready with random stall bursts and one long hold
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic instr_t mk(op_t op, int imm, int mi, int dr, int sr, int fr);
    instr_t m;
    m.opcode = op;
    m.immediate = imm[3:0];
    m.mem_index = mi[1:0];
    m.dest_reg = dr[0];
    m.src_reg = sr[0];
    m.out_from_registers = fr[0];
    return m;
  endfunction

  // any opcode but halt, which would freeze the machine for good
  function automatic op_t pick_op();
    int v;
    v = $urandom_range(0, 15);
    if (v == OP_HALT) v = $urandom_range(13, 15);
    return op_t'(v);
  endfunction

  function automatic instr_t rand_instr(op_t op);
    return mk(op, $urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 1),
              $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  // offer one beat and hold it until taken, then maybe pause
  task automatic put(instr_t ins);
    in_valid <= 1'b1;
    opcode <= ins.opcode;
    immediate <= ins.immediate;
    mem_index <= ins.mem_index;
    dest_reg <= ins.dest_reg;
    src_reg <= ins.src_reg;
    out_from_registers <= ins.out_from_registers;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // one edge first so the last accepted beat is already noted
  task automatic wait_drained();
    @(posedge clk);
    while (sb.state_q.size() != 0) @(posedge clk);
  endtask

  // directed: extremes, every operation but halt, taken and untaken branches, wrap
  task automatic run_directed();
    put(mk(OP_LUI, 15, 0, 0, 0, 0));
    put(mk(OP_LLI, 15, 0, 0, 0, 0));
    put(mk(OP_STORE, 0, 3, 0, 0, 0));
    put(mk(OP_LOAD, 0, 3, 1, 0, 0));
    put(mk(OP_ADD, 0, 0, 0, 0, 0));
    put(mk(OP_INC, 0, 0, 1, 1, 0));
    put(mk(OP_SUB, 0, 0, 1, 0, 0));
    put(mk(OP_JIN, 15, 0, 0, 0, 0));
    put(mk(OP_NOP, 0, 0, 0, 0, 0));
    put(mk(OP_OUT, 0, 0, 1, 0, 1));
    put(mk(OP_OUT, 0, 3, 0, 0, 0));
    put(mk(OP_HALVE, 0, 0, 0, 0, 0));
    put(mk(OP_DOUBLE, 0, 0, 1, 1, 0));
    put(mk(OP_HALVE, 0, 0, 1, 1, 0));
    put(mk(OP_JIA, 9, 0, 0, 0, 0));
    put(mk(OP_LUI, 0, 0, 0, 0, 0));
    put(mk(OP_HALVE, 0, 0, 0, 0, 0));
    put(mk(OP_JIZ, 3, 0, 0, 0, 0));
    put(mk(OP_JIA, 5, 0, 0, 0, 0));
    put(mk(OP_JIN, 6, 0, 0, 0, 0));
    put(mk(OP_JMP, 0, 0, 0, 0, 0));
    put(mk(OP_STORE, 0, 0, 1, 0, 0));
    put(mk(OP_LOAD, 0, 0, 0, 0, 0));
  endtask

  // build an operand, set flags from it, then branch on them
  task automatic put_flag_branch();
    op_t arith [5];
    op_t jumps [3];
    arith = '{OP_ADD, OP_SUB, OP_HALVE, OP_DOUBLE, OP_INC};
    jumps = '{OP_JIN, OP_JIZ, OP_JIA};
    put(rand_instr(OP_LUI));
    put(rand_instr(OP_LLI));
    put(rand_instr(arith[$urandom_range(0, 4)]));
    put(rand_instr(jumps[$urandom_range(0, 2)]));
  endtask

  // main sequence
  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    immediate = '0;
    mem_index = '0;
    dest_reg = 1'b0;
    src_reg = 1'b0;
    out_from_registers = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int n = 0; n < 630; n++) begin
      if (n == 200) hold_req = 1'b1;
      if (n == 400) begin
        in_valid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
      if (n == 560) idle_on = 1'b0;
      if ($urandom_range(0, 7) == 0) put_flag_branch();
      else put(rand_instr(pick_op()));
    end

    // stop the machine, then confirm later beats change nothing
    put(mk(OP_HALT, 0, 0, 0, 0, 0));
    for (int n = 0; n < 6; n++) put(rand_instr(op_t'($urandom_range(0, 15))));

    in_valid <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.state_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.state_q.size()));
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
